// File: rtl/core/mse_pkg.sv
package mse_pkg;

    // Default geometry
    localparam int DATA_WORDS_DEF    = 4096;
    localparam int PROGRAM_DEPTH_DEF = 1024;
    localparam int REG_COUNT         = 32;
    localparam int REG_SEL_BITS      = 5;
    localparam int NEXT_INDEX_BITS   = 10;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Register numbers with special meaning
    localparam logic [REG_SEL_BITS-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_T0   = 5'd8;
    localparam logic [REG_SEL_BITS-1:0] REG_T1   = 5'd9;
    localparam logic [REG_SEL_BITS-1:0] REG_T2   = 5'd10;
    localparam logic [REG_SEL_BITS-1:0] REG_SP   = 5'd29;
    localparam logic [REG_SEL_BITS-1:0] REG_LINK = 5'd31;

    // Register file values after reset
    localparam logic [31:0] SP_RESET = 32'd4095;
    localparam logic [31:0] T0_RESET = 32'hFFFF_FFFC;
    localparam logic [31:0] T1_RESET = 32'd2;
    localparam logic [31:0] T2_RESET = 32'd3;

    // Configuration registers
    localparam int          CFG_ADDR_BITS = 4;
    localparam logic [1:0]  CFG_ALU       = 2'd0;
    localparam logic [1:0]  CFG_MEMORY    = 2'd1;
    localparam logic [1:0]  CFG_BRANCH    = 2'd2;
    localparam logic [1:0]  CFG_JUMP      = 2'd3;
    localparam logic [7:0]  DELAY_RESET   = 8'd5;

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_SLL  = 4'd2,
        FN_SRL  = 4'd3,
        FN_SW   = 4'd4,
        FN_LW   = 4'd5,
        FN_BNE  = 4'd6,
        FN_BEQ  = 4'd7,
        FN_J    = 4'd8,
        FN_JR   = 4'd9,
        FN_JAL  = 4'd10,
        FN_BLEZ = 4'd11,
        FN_BGTZ = 4'd12,
        FN_BAD  = 4'd13
    } t_func;

    typedef enum logic [2:0] {
        CLS_ALU,
        CLS_MEM,
        CLS_BRANCH,
        CLS_JUMP,
        CLS_BAD
    } t_cls;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_ADDR    = 2'd2,
        ST_TARGET  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BS_READ,
        BS_EXEC,
        BS_LOAD
    } t_bstate;

    // One classified instruction as it sits in the queue
    typedef struct packed {
        t_func                   func;
        t_cls                    cls;
        logic [REG_SEL_BITS-1:0] dest_sel;
        logic [REG_SEL_BITS-1:0] ra_sel;
        logic [REG_SEL_BITS-1:0] rb_sel;
        logic [REG_SEL_BITS-1:0] data_sel;
        logic signed [15:0]      imm;
    } t_op;

    typedef struct packed {
        logic [7:0] alu;
        logic [7:0] memory;
        logic [7:0] branch;
        logic [7:0] jump;
    } t_delays;

    // Register file contents after reset
    function automatic logic [31:0] rf_reset_value(input logic [REG_SEL_BITS-1:0] sel);
        logic [31:0] v;
        v = '0;
        if (sel == REG_SP) v = SP_RESET;
        if (sel == REG_T0) v = T0_RESET;
        if (sel == REG_T1) v = T1_RESET;
        if (sel == REG_T2) v = T2_RESET;
        return v;
    endfunction

endpackage

// File: rtl/core/mips_subset_execute_unit.sv
// Executes a small MIPS subset, one decoded instruction per input word.
// Input channel: i_in_valid / o_in_stall with func, register selects and
// immediate; a word is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with next index, status, register
// write flag and value, and the running cycle total; one result per word.
// The APB port sets the four per-class delays (byte address 4*i); pready is
// always high and reads return the stored value.
// A word moves from the queue into the register file read registers, for LW
// then into the load data register, and then into the output register. The
// back-end sequencer works on one word at a time: register file read, then
// execute and writeback, plus a data memory read state for loads. A 2-entry
// queue between the front decoder and the back end takes words while the back
// end works; the output register lets a word be read while a result waits.
// Reset: registers and cycle total return to their initial values, delays
// to 5, and a clearing pass then zeroes every word of the data memory while
// o_in_stall stays high. Configuration writes are taken throughout.
// When the receiver stalls, the result holds and the back end waits; the
// queue fills and then o_in_stall rises.
module mips_subset_execute_unit #(
    parameter int DATA_WORDS    = mse_pkg::DATA_WORDS_DEF,
    parameter int PROGRAM_DEPTH = mse_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [3:0]                          i_func,
    input  logic [mse_pkg::REG_SEL_BITS-1:0]    i_dest_sel,
    input  logic [mse_pkg::REG_SEL_BITS-1:0]    i_first_sel,
    input  logic [mse_pkg::REG_SEL_BITS-1:0]    i_second_sel,
    input  logic signed [15:0]                  i_immediate,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mse_pkg::NEXT_INDEX_BITS-1:0] o_next_index,
    output logic [1:0]                          o_status,
    output logic                                o_reg_written,
    output logic signed [31:0]                  o_written_value,
    output logic [31:0]                         o_total_cycles,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mse_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    mse_pkg::t_delays r_delays;
    mse_pkg::t_op     q_op;
    logic             q_valid, q_pop, clearing, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Delay registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delays.alu    <= mse_pkg::DELAY_RESET;
            r_delays.memory <= mse_pkg::DELAY_RESET;
            r_delays.branch <= mse_pkg::DELAY_RESET;
            r_delays.jump   <= mse_pkg::DELAY_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mse_pkg::CFG_ALU:    r_delays.alu    <= pwdata[7:0];
                mse_pkg::CFG_MEMORY: r_delays.memory <= pwdata[7:0];
                mse_pkg::CFG_BRANCH: r_delays.branch <= pwdata[7:0];
                mse_pkg::CFG_JUMP:   r_delays.jump   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            mse_pkg::CFG_ALU:    prdata = {24'd0, r_delays.alu};
            mse_pkg::CFG_MEMORY: prdata = {24'd0, r_delays.memory};
            mse_pkg::CFG_BRANCH: prdata = {24'd0, r_delays.branch};
            mse_pkg::CFG_JUMP:   prdata = {24'd0, r_delays.jump};
            default:             prdata = 32'd0;
        endcase
    end

    mse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_dest_sel   (i_dest_sel),
        .i_first_sel  (i_first_sel),
        .i_second_sel (i_second_sel),
        .i_immediate  (i_immediate),
        .i_hold       (clearing),
        .o_q_valid    (q_valid),
        .o_q_op       (q_op),
        .i_q_pop      (q_pop)
    );

    mse_back #(
        .DATA_WORDS    (DATA_WORDS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (q_op),
        .o_q_pop         (q_pop),
        .i_delays        (r_delays),
        .o_clearing      (clearing),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_index    (o_next_index),
        .o_status        (o_status),
        .o_reg_written   (o_reg_written),
        .o_written_value (o_written_value),
        .o_total_cycles  (o_total_cycles)
    );

endmodule

// File: rtl/core/mse_front.sv
module mse_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [3:0]                          i_func,
    input  logic [mse_pkg::REG_SEL_BITS-1:0]    i_dest_sel,
    input  logic [mse_pkg::REG_SEL_BITS-1:0]    i_first_sel,
    input  logic [mse_pkg::REG_SEL_BITS-1:0]    i_second_sel,
    input  logic signed [15:0]                  i_immediate,
    input  logic                                i_hold,
    output logic                                o_q_valid,
    output mse_pkg::t_op                        o_q_op,
    input  logic                                i_q_pop
);

    mse_pkg::t_op                 q_mem [mse_pkg::QUEUE_DEPTH];
    logic [mse_pkg::QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [mse_pkg::QPTR_BITS:0]   r_count;
    mse_pkg::t_op                 dec_op;
    logic                         push;
    logic                         full;

    // Classify the incoming word
    always_comb begin
        dec_op.dest_sel = i_dest_sel;
        dec_op.ra_sel   = i_first_sel;
        dec_op.rb_sel   = i_second_sel;
        dec_op.data_sel = i_second_sel;
        dec_op.imm      = i_immediate;
        dec_op.func     = mse_pkg::t_func'(i_func);
        case (mse_pkg::t_func'(i_func))
            mse_pkg::FN_ADD, mse_pkg::FN_SUB,
            mse_pkg::FN_SLL, mse_pkg::FN_SRL: dec_op.cls = mse_pkg::CLS_ALU;
            mse_pkg::FN_SW, mse_pkg::FN_LW:   dec_op.cls = mse_pkg::CLS_MEM;
            mse_pkg::FN_BNE, mse_pkg::FN_BEQ,
            mse_pkg::FN_BLEZ, mse_pkg::FN_BGTZ: dec_op.cls = mse_pkg::CLS_BRANCH;
            mse_pkg::FN_J, mse_pkg::FN_JAL:   dec_op.cls = mse_pkg::CLS_JUMP;
            mse_pkg::FN_JR: begin
                dec_op.cls    = mse_pkg::CLS_JUMP;
                dec_op.rb_sel = mse_pkg::REG_LINK;
            end
            default: begin
                dec_op.cls  = mse_pkg::CLS_BAD;
                dec_op.func = mse_pkg::FN_BAD;
            end
        endcase
    end

    assign full       = (r_count == (mse_pkg::QPTR_BITS+1)'(mse_pkg::QUEUE_DEPTH));
    assign o_in_stall = full || i_hold;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_op     = q_mem[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) q_mem[r_wr_ptr] <= dec_op;
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_q_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !i_q_pop) r_count <= r_count + 1'b1;
            else if (!push && i_q_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: rtl/core/mse_back.sv
module mse_back #(
    parameter int DATA_WORDS    = mse_pkg::DATA_WORDS_DEF,
    parameter int PROGRAM_DEPTH = mse_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    input  mse_pkg::t_op                           i_q_op,
    output logic                                   o_q_pop,
    input  mse_pkg::t_delays                       i_delays,
    output logic                                   o_clearing,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [mse_pkg::NEXT_INDEX_BITS-1:0]    o_next_index,
    output logic [1:0]                             o_status,
    output logic                                   o_reg_written,
    output logic signed [31:0]                     o_written_value,
    output logic [31:0]                            o_total_cycles
);

    localparam int DW_BITS = $clog2(DATA_WORDS);
    localparam int PI_BITS = $clog2(PROGRAM_DEPTH);

    // Storage
    logic [31:0] rf [mse_pkg::REG_COUNT];
    logic [mse_pkg::REG_COUNT-1:0] r_rf_valid;
    logic [31:0] dmem [DATA_WORDS];

    mse_pkg::t_bstate r_state, n_state;
    mse_pkg::t_op     r_op;
    logic [31:0]      r_a_data, r_b_data;
    logic             r_a_valid, r_b_valid;
    logic [31:0]      r_mem_q;
    logic [PI_BITS-1:0] r_index;
    logic [31:0]      r_total;
    logic             r_clearing;
    logic [DW_BITS-1:0] r_clr_addr;

    logic               r_out_valid;
    logic [mse_pkg::NEXT_INDEX_BITS-1:0] r_out_next;
    mse_pkg::t_status   r_out_status;
    logic               r_out_wr;
    logic [31:0]        r_out_wval;
    logic [31:0]        r_out_total;

    // Execute-stage values
    logic [31:0]        a_val, b_val;
    logic [32:0]        imm33, addr33, tgt33;
    logic               addr_ok, tgt_ok, take;
    logic [PI_BITS-1:0] seq_index;
    logic [DW_BITS-1:0] addr_idx;
    mse_pkg::t_status   ex_status;
    logic [PI_BITS-1:0] ex_next;
    logic               ex_wr;
    logic [mse_pkg::REG_SEL_BITS-1:0] ex_wsel;
    logic [31:0]        ex_wval;
    logic [7:0]         ex_delay;

    // Commit-side values
    logic               out_free, q_pop, emit, mem_rd, mem_wr, rf_we;
    mse_pkg::t_status   c_status;
    logic [PI_BITS-1:0] c_next;
    logic               c_wr;
    logic [mse_pkg::REG_SEL_BITS-1:0] c_wsel;
    logic [31:0]        c_wval;
    logic [7:0]         c_delay;
    logic [32:0]        total_sum;
    logic [31:0]        n_total;
    logic [31:0]        next_ext;

    // Resolve register reads: zero register, then never-written entries
    assign a_val = (r_op.ra_sel == mse_pkg::REG_ZERO) ? 32'd0 :
                   r_a_valid ? r_a_data : mse_pkg::rf_reset_value(r_op.ra_sel);
    assign b_val = (r_op.rb_sel == mse_pkg::REG_ZERO) ? 32'd0 :
                   r_b_valid ? r_b_data : mse_pkg::rf_reset_value(r_op.rb_sel);

    assign imm33     = {{17{r_op.imm[15]}}, r_op.imm};
    assign addr33    = {a_val[31], a_val} + imm33;
    assign addr_ok   = !addr33[32] && (addr33 < 33'(DATA_WORDS));
    assign addr_idx  = addr33[DW_BITS-1:0];
    assign tgt33     = (r_op.func == mse_pkg::FN_JR) ? {b_val[31], b_val} : imm33;
    assign tgt_ok    = !tgt33[32] && (tgt33 < 33'(PROGRAM_DEPTH));
    assign seq_index = (r_index == PI_BITS'(PROGRAM_DEPTH - 1)) ? '0 : r_index + 1'b1;

    // Execute one instruction
    always_comb begin
        ex_status = mse_pkg::ST_OK;
        ex_wr     = 1'b0;
        ex_wsel   = r_op.dest_sel;
        ex_wval   = 32'd0;
        take      = 1'b0;
        case (r_op.func)
            mse_pkg::FN_ADD: begin ex_wr = 1'b1; ex_wval = a_val + b_val; end
            mse_pkg::FN_SUB: begin ex_wr = 1'b1; ex_wval = a_val - b_val; end
            mse_pkg::FN_SLL: begin ex_wr = 1'b1; ex_wval = a_val << r_op.imm[4:0]; end
            mse_pkg::FN_SRL: begin ex_wr = 1'b1; ex_wval = a_val >> r_op.imm[4:0]; end
            mse_pkg::FN_SW, mse_pkg::FN_LW: begin
                if (!addr_ok) ex_status = mse_pkg::ST_ADDR;
            end
            mse_pkg::FN_BNE:  take = (a_val != b_val);
            mse_pkg::FN_BEQ:  take = (a_val == b_val);
            mse_pkg::FN_J:    take = 1'b1;
            mse_pkg::FN_JR:   take = 1'b1;
            mse_pkg::FN_JAL: begin
                take    = 1'b1;
                ex_wr   = 1'b1;
                ex_wsel = mse_pkg::REG_LINK;
                ex_wval = 32'(seq_index);
            end
            mse_pkg::FN_BLEZ: take = a_val[31] || (a_val == 32'd0);
            mse_pkg::FN_BGTZ: take = !a_val[31] && (a_val != 32'd0);
            default: ex_status = mse_pkg::ST_INVALID;
        endcase

        ex_next = seq_index;
        if (take) begin
            if (tgt_ok) ex_next = tgt33[PI_BITS-1:0];
            else ex_status = mse_pkg::ST_TARGET;
        end

        case (r_op.cls)
            mse_pkg::CLS_ALU:    ex_delay = i_delays.alu;
            mse_pkg::CLS_MEM:    ex_delay = i_delays.memory;
            mse_pkg::CLS_BRANCH: ex_delay = i_delays.branch;
            mse_pkg::CLS_JUMP:   ex_delay = i_delays.jump;
            default:             ex_delay = 8'd0;
        endcase

        // Drop all effects on error
        if (ex_status != mse_pkg::ST_OK) begin
            ex_next  = r_index;
            ex_wr    = 1'b0;
            ex_wval  = 32'd0;
            ex_delay = 8'd0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer: read, execute, optional load
    always_comb begin
        n_state = r_state;
        q_pop   = 1'b0;
        emit    = 1'b0;
        mem_rd  = 1'b0;
        mem_wr  = 1'b0;
        case (r_state)
            mse_pkg::BS_READ: begin
                if (i_q_valid && !r_clearing) begin
                    q_pop   = 1'b1;
                    n_state = mse_pkg::BS_EXEC;
                end
            end
            mse_pkg::BS_EXEC: begin
                if (r_op.func == mse_pkg::FN_LW && ex_status == mse_pkg::ST_OK) begin
                    mem_rd  = 1'b1;
                    n_state = mse_pkg::BS_LOAD;
                end else if (out_free) begin
                    emit    = 1'b1;
                    mem_wr  = (r_op.func == mse_pkg::FN_SW) && (ex_status == mse_pkg::ST_OK);
                    n_state = mse_pkg::BS_READ;
                end
            end
            mse_pkg::BS_LOAD: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = mse_pkg::BS_READ;
                end
            end
            default: n_state = mse_pkg::BS_READ;
        endcase
    end

    // Pick what retires this cycle
    always_comb begin
        if (r_state == mse_pkg::BS_LOAD) begin
            c_status = mse_pkg::ST_OK;
            c_next   = seq_index;
            c_wr     = 1'b1;
            c_wsel   = r_op.data_sel;
            c_wval   = r_mem_q;
            c_delay  = i_delays.memory;
        end else begin
            c_status = ex_status;
            c_next   = ex_next;
            c_wr     = ex_wr;
            c_wsel   = ex_wsel;
            c_wval   = ex_wval;
            c_delay  = ex_delay;
        end
        // Writes to the zero register are discarded
        if (c_wsel == mse_pkg::REG_ZERO) begin
            c_wr   = 1'b0;
            c_wval = 32'd0;
        end
        if (!c_wr) c_wval = 32'd0;
    end

    assign rf_we     = emit && c_wr;
    assign total_sum = {1'b0, r_total} + 33'(c_delay);
    assign n_total   = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
    assign next_ext  = 32'(c_next);

    // Register file: two registered reads, one write
    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_a_data <= rf[i_q_op.ra_sel];
            r_b_data <= rf[i_q_op.rb_sel];
        end
        if (rf_we) rf[c_wsel] <= c_wval;
    end

    // Register file valid bits and read-side copies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
        end else begin
            if (q_pop) begin
                r_a_valid <= r_rf_valid[i_q_op.ra_sel];
                r_b_valid <= r_rf_valid[i_q_op.rb_sel];
            end
            if (rf_we) r_rf_valid[c_wsel] <= 1'b1;
        end
    end

    // Data memory: clear sweep, store, registered load
    always_ff @(posedge i_clk) begin
        if (r_clearing) dmem[r_clr_addr] <= 32'd0;
        else if (mem_wr) dmem[addr_idx] <= b_val;
        if (mem_rd) r_mem_q <= dmem[addr_idx];
    end

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == DW_BITS'(DATA_WORDS - 1)) r_clearing <= 1'b0;
            else r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Hold the instruction being worked on
    always_ff @(posedge i_clk) begin
        if (q_pop) r_op <= i_q_op;
    end

    // Architectural state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::BS_READ;
            r_index <= '0;
            r_total <= 32'd0;
        end else begin
            r_state <= n_state;
            if (emit && c_status == mse_pkg::ST_OK) begin
                r_index <= c_next;
                r_total <= n_total;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (emit) r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_next   <= next_ext[mse_pkg::NEXT_INDEX_BITS-1:0];
            r_out_status <= c_status;
            r_out_wr     <= c_wr;
            r_out_wval   <= c_wval;
            r_out_total  <= (c_status == mse_pkg::ST_OK) ? n_total : r_total;
        end
    end

    assign o_q_pop         = q_pop;
    assign o_clearing      = r_clearing;
    assign o_out_valid     = r_out_valid;
    assign o_next_index    = r_out_next;
    assign o_status        = r_out_status;
    assign o_reg_written   = r_out_wr;
    assign o_written_value = r_out_wval;
    assign o_total_cycles  = r_out_total;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Top of the 4-bit func field, one of the invalid codes
    localparam logic [3:0] FN_TOP = 4'hF;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 80;

    typedef struct packed {
        logic [3:0]  func;
        logic [4:0]  dest_sel;
        logic [4:0]  first_sel;
        logic [4:0]  second_sel;
        logic [15:0] immediate;
    } t_word;

    typedef struct packed {
        logic [9:0]  next_index;
        logic [1:0]  status;
        logic        reg_written;
        logic [31:0] written_value;
        logic [31:0] total_cycles;
    } t_result;

    // One directed row: the word, and a typed-in result where it is obvious
    typedef struct {
        t_word   word;
        bit      typed;
        t_result want;
    } t_row;

    typedef enum {RX_OPEN, RX_PATCHY, RX_HEAVY} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [3:0]  i_func = '0;
    logic [4:0]  i_dest_sel = '0;
    logic [4:0]  i_first_sel = '0;
    logic [4:0]  i_second_sel = '0;
    logic [15:0] i_immediate = '0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [9:0]  o_next_index;
    logic [1:0]  o_status;
    logic        o_reg_written;
    logic [31:0] o_written_value;
    logic [31:0] o_total_cycles;
    logic [31:0] prdata;
    logic        pready;

    // Shadow machine state
    logic [31:0] gpr [mse_pkg::REG_COUNT];
    logic [31:0] data_store [mse_pkg::DATA_WORDS_DEF];
    logic [9:0]  pc;
    logic [31:0] cycle_sum;
    logic [7:0]  class_delay [4];

    t_result  pending_results [$];
    t_result  oldest;
    int       fail_count = 0;
    int       burst_left = 0;
    t_rx_mode stall_mode = RX_OPEN;
    int       stall_timer = 0;

    t_row directed_rows [27] = '{
        '{'{mse_pkg::FN_ADD, 5'd1, mse_pkg::REG_T1, mse_pkg::REG_T2, 16'd0}, 1'b1,
          '{10'd1, mse_pkg::ST_OK, 1'b1, 32'd5, 32'd5}},
        '{'{mse_pkg::FN_SUB, 5'd2, mse_pkg::REG_T0, mse_pkg::REG_T1, 16'd0}, 1'b1,
          '{10'd2, mse_pkg::ST_OK, 1'b1, 32'hFFFF_FFFA, 32'd10}},
        '{'{mse_pkg::FN_ADD, mse_pkg::REG_ZERO, mse_pkg::REG_T1, mse_pkg::REG_T2, 16'd0},
          1'b1, '{10'd3, mse_pkg::ST_OK, 1'b0, 32'd0, 32'd15}},
        '{'{mse_pkg::FN_ADD, 5'd3, 5'd2, mse_pkg::REG_SP, 16'd0}, 1'b0, '0},
        '{'{mse_pkg::FN_SLL, 5'd4, mse_pkg::REG_T0, mse_pkg::REG_ZERO, 16'h8021},
          1'b0, '0},
        '{'{mse_pkg::FN_SRL, 5'd5, mse_pkg::REG_T0, mse_pkg::REG_ZERO, 16'h7FFF}, 1'b1,
          '{10'd6, mse_pkg::ST_OK, 1'b1, 32'd1, 32'd30}},
        '{'{mse_pkg::FN_SRL, 5'd6, mse_pkg::REG_T0, mse_pkg::REG_ZERO, 16'h8000},
          1'b0, '0},
        '{'{mse_pkg::FN_SW, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, mse_pkg::REG_T1, 16'd4095},
          1'b0, '0},
        '{'{mse_pkg::FN_LW, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 5'd7, 16'd4095},
          1'b0, '0},
        '{'{mse_pkg::FN_LW, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 5'd7, 16'hFFFF},
          1'b1, '{10'd9, mse_pkg::ST_ADDR, 1'b0, 32'd0, 32'd45}},
        '{'{mse_pkg::FN_SW, mse_pkg::REG_ZERO, mse_pkg::REG_SP, mse_pkg::REG_T1, 16'd1},
          1'b1, '{10'd9, mse_pkg::ST_ADDR, 1'b0, 32'd0, 32'd45}},
        '{'{mse_pkg::FN_SW, mse_pkg::REG_ZERO, mse_pkg::REG_SP, 5'd1, 16'hF001},
          1'b0, '0},
        '{'{mse_pkg::FN_LW, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 5'd11, 16'd0},
          1'b0, '0},
        '{'{mse_pkg::FN_BAD, 5'd1, mse_pkg::REG_T1, mse_pkg::REG_T2, 16'd0}, 1'b1,
          '{10'd11, mse_pkg::ST_INVALID, 1'b0, 32'd0, 32'd55}},
        '{'{FN_TOP, mse_pkg::REG_LINK, mse_pkg::REG_LINK, mse_pkg::REG_LINK, 16'hFFFF},
          1'b1, '{10'd11, mse_pkg::ST_INVALID, 1'b0, 32'd0, 32'd55}},
        '{'{mse_pkg::FN_BEQ, mse_pkg::REG_ZERO, mse_pkg::REG_T1, mse_pkg::REG_T1, 16'd1023},
          1'b0, '0},
        '{'{mse_pkg::FN_J, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'h7FFF},
          1'b1, '{10'd1023, mse_pkg::ST_TARGET, 1'b0, 32'd0, 32'd60}},
        '{'{mse_pkg::FN_JAL, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO,
            16'd100},
          1'b1, '{10'd100, mse_pkg::ST_OK, 1'b1, 32'd0, 32'd65}},
        '{'{mse_pkg::FN_BNE, mse_pkg::REG_ZERO, mse_pkg::REG_T1, mse_pkg::REG_T2, 16'hFFFF},
          1'b1, '{10'd100, mse_pkg::ST_TARGET, 1'b0, 32'd0, 32'd65}},
        '{'{mse_pkg::FN_BNE, mse_pkg::REG_ZERO, mse_pkg::REG_T1, mse_pkg::REG_T1, 16'h8000},
          1'b0, '0},
        '{'{mse_pkg::FN_BLEZ, mse_pkg::REG_ZERO, mse_pkg::REG_T0, mse_pkg::REG_ZERO,
            16'd200},
          1'b0, '0},
        '{'{mse_pkg::FN_BGTZ, mse_pkg::REG_ZERO, mse_pkg::REG_T0, mse_pkg::REG_ZERO,
            16'hFFFF},
          1'b0, '0},
        '{'{mse_pkg::FN_BGTZ, mse_pkg::REG_ZERO, mse_pkg::REG_T1, mse_pkg::REG_ZERO,
            16'd1024},
          1'b1, '{10'd201, mse_pkg::ST_TARGET, 1'b0, 32'd0, 32'd80}},
        '{'{mse_pkg::FN_BLEZ, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO,
            16'd0},
          1'b0, '0},
        '{'{mse_pkg::FN_JR, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'd0},
          1'b0, '0},
        '{'{mse_pkg::FN_ADD, mse_pkg::REG_LINK, mse_pkg::REG_T0, mse_pkg::REG_ZERO, 16'd0},
          1'b0, '0},
        '{'{mse_pkg::FN_JR, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'd0},
          1'b1, '{10'd1, mse_pkg::ST_TARGET, 1'b0, 32'd0, 32'd95}}
    };

    mips_subset_execute_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_dest_sel      (i_dest_sel),
        .i_first_sel     (i_first_sel),
        .i_second_sel    (i_second_sel),
        .i_immediate     (i_immediate),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_index    (o_next_index),
        .o_status        (o_status),
        .o_reg_written   (o_reg_written),
        .o_written_value (o_written_value),
        .o_total_cycles  (o_total_cycles),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bring the shadow state to its power-up values
    task automatic reset_machine();
        foreach (gpr[k]) gpr[k] = '0;
        foreach (data_store[k]) data_store[k] = '0;
        gpr[mse_pkg::REG_SP] = mse_pkg::SP_RESET;
        gpr[mse_pkg::REG_T0] = mse_pkg::T0_RESET;
        gpr[mse_pkg::REG_T1] = mse_pkg::T1_RESET;
        gpr[mse_pkg::REG_T2] = mse_pkg::T2_RESET;
        pc = '0;
        cycle_sum = '0;
        foreach (class_delay[k]) class_delay[k] = mse_pkg::DELAY_RESET;
    endtask

    // Execute one word on the shadow state and return its result.
    // Register zero is never written, so reading gpr[0] gives zero.
    task automatic execute_word(input t_word w, output t_result r);
        logic [31:0] a, b, wval;
        logic [9:0]  seq, nxt;
        logic [1:0]  st;
        logic [7:0]  dly;
        logic [4:0]  wsel;
        logic        wr, taken;
        longint      imm, addr, tgt;
        logic [32:0] sum;
        a = gpr[w.first_sel];
        b = gpr[w.second_sel];
        imm = longint'($signed(w.immediate));
        seq = (pc == mse_pkg::PROGRAM_DEPTH_DEF - 1) ? '0 : pc + 10'd1;
        nxt = seq;
        st = mse_pkg::ST_OK;
        dly = '0;
        wr = 1'b0;
        wsel = mse_pkg::REG_ZERO;
        wval = '0;
        taken = 1'b0;
        tgt = imm;
        case (w.func)
            mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_SLL, mse_pkg::FN_SRL: begin
                wr = 1'b1;
                wsel = w.dest_sel;
                dly = class_delay[mse_pkg::CFG_ALU];
                case (w.func)
                    mse_pkg::FN_ADD: wval = a + b;
                    mse_pkg::FN_SUB: wval = a - b;
                    mse_pkg::FN_SLL: wval = a << w.immediate[4:0];
                    default: wval = a >> w.immediate[4:0];
                endcase
            end
            mse_pkg::FN_SW, mse_pkg::FN_LW: begin
                addr = longint'($signed(a)) + imm;
                dly = class_delay[mse_pkg::CFG_MEMORY];
                if (addr < 0 || addr >= mse_pkg::DATA_WORDS_DEF) begin
                    st = mse_pkg::ST_ADDR;
                end else if (w.func == mse_pkg::FN_SW) begin
                    data_store[int'(addr)] = b;
                end else begin
                    wr = 1'b1;
                    wsel = w.second_sel;
                    wval = data_store[int'(addr)];
                end
            end
            mse_pkg::FN_BNE: begin
                taken = (a != b);
                dly = class_delay[mse_pkg::CFG_BRANCH];
            end
            mse_pkg::FN_BEQ: begin
                taken = (a == b);
                dly = class_delay[mse_pkg::CFG_BRANCH];
            end
            mse_pkg::FN_BLEZ: begin
                taken = ($signed(a) <= 0);
                dly = class_delay[mse_pkg::CFG_BRANCH];
            end
            mse_pkg::FN_BGTZ: begin
                taken = ($signed(a) > 0);
                dly = class_delay[mse_pkg::CFG_BRANCH];
            end
            mse_pkg::FN_J: begin
                taken = 1'b1;
                dly = class_delay[mse_pkg::CFG_JUMP];
            end
            mse_pkg::FN_JR: begin
                taken = 1'b1;
                tgt = longint'($signed(gpr[mse_pkg::REG_LINK]));
                dly = class_delay[mse_pkg::CFG_JUMP];
            end
            mse_pkg::FN_JAL: begin
                taken = 1'b1;
                dly = class_delay[mse_pkg::CFG_JUMP];
                wr = 1'b1;
                wsel = mse_pkg::REG_LINK;
                wval = 32'(seq);
            end
            default: st = mse_pkg::ST_INVALID;
        endcase

        // Resolve the target only for taken control transfers
        if (st == mse_pkg::ST_OK && taken) begin
            if (tgt >= 0 && tgt < mse_pkg::PROGRAM_DEPTH_DEF) nxt = 10'(tgt);
            else st = mse_pkg::ST_TARGET;
        end

        // Errors leave the machine untouched
        if (st != mse_pkg::ST_OK) begin
            nxt = pc;
            wr = 1'b0;
            wval = '0;
        end else begin
            if (wr && wsel != mse_pkg::REG_ZERO) begin
                gpr[wsel] = wval;
            end else begin
                wr = 1'b0;
                wval = '0;
            end
            sum = {1'b0, cycle_sum} + 33'(dly);
            cycle_sum = sum[32] ? '1 : sum[31:0];
            pc = nxt;
        end
        r = '{nxt, st, wr, wval, cycle_sum};
    endtask

    // Mostly well-formed words with random content, some raw noise
    function automatic t_word random_word();
        t_word w;
        w.func       = 4'($urandom_range(0, 12));
        w.dest_sel   = 5'($urandom);
        w.first_sel  = 5'($urandom);
        w.second_sel = 5'($urandom);
        w.immediate  = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            w.func = 4'($urandom);
            return w;
        end
        case (w.func)
            mse_pkg::FN_SW, mse_pkg::FN_LW: begin
                // keep addresses mostly in range; a small window makes loads hit stores
                case ($urandom_range(0, 3))
                    0: begin
                        w.first_sel = mse_pkg::REG_ZERO;
                        w.immediate = 16'($urandom_range(0, 15));
                    end
                    1: begin
                        w.first_sel = mse_pkg::REG_ZERO;
                        w.immediate = 16'($urandom_range(0, mse_pkg::DATA_WORDS_DEF - 1));
                    end
                    2: begin
                        w.first_sel = mse_pkg::REG_SP;
                        w.immediate = 16'(-$urandom_range(0, 15));
                    end
                    default: ;
                endcase
            end
            mse_pkg::FN_BNE, mse_pkg::FN_BEQ, mse_pkg::FN_BLEZ, mse_pkg::FN_BGTZ,
            mse_pkg::FN_J, mse_pkg::FN_JAL: begin
                if ($urandom_range(0, 2) == 0) w.second_sel = w.first_sel;
                if ($urandom_range(0, 7) != 0)
                    w.immediate = 16'($urandom_range(0, mse_pkg::PROGRAM_DEPTH_DEF - 1));
            end
            default: ;
        endcase
        return w;
    endfunction

    // Present one word, hold it until taken, then record its result
    task automatic send_word(input t_word w, input bit typed, input t_result typed_res);
        t_result r;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid   <= 1'b1;
        i_func       <= w.func;
        i_dest_sel   <= w.dest_sel;
        i_first_sel  <= w.first_sel;
        i_second_sel <= w.second_sel;
        i_immediate  <= w.immediate;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        execute_word(w, r);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    // Drop valid and wait until every result is back, plus some cycles
    task automatic drain_results(input int extra);
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready, then idle
    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        class_delay[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    // Receiver: switch between open, patchy and heavy stalling
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  <= t_rx_mode'($urandom_range(0, 2));
            stall_timer <= $urandom_range(20, 120);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            RX_OPEN:   i_out_stall <= 1'b0;
            RX_PATCHY: i_out_stall <= 1'($urandom_range(0, 1));
            default:   i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Compare each taken result word with the oldest outstanding one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding");
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("next_index", 32'(oldest.next_index), 32'(o_next_index));
                check_field("status", 32'(oldest.status), 32'(o_status));
                check_field("reg_written", 32'(oldest.reg_written), 32'(o_reg_written));
                check_field("written_value", oldest.written_value, o_written_value);
                check_field("total_cycles", oldest.total_cycles, o_total_cycles);
            end
        end
    end

    initial begin
        int phase;
        int n;
        int c;
        logic [7:0] val;
        reset_machine();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words with the power-up delays
        foreach (directed_rows[k])
            send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);

        // Random phases, each under its own delay setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results(4);
            for (c = 0; c < 4; c++) begin
                case (phase)
                    0: val = 8'd0;
                    1: val = 8'd255;
                    3: val = c[0] ? 8'd255 : 8'd0;
                    default: val = 8'($urandom);
                endcase
                cfg_write(2'(c), val);
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 49) == 0) drain_results(0);
                send_word(random_word(), 1'b0, '0);
            end
        end

        drain_results(8);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/mse_pkg.sv
rtl/core/mse_front.sv
rtl/core/mse_back.sv
rtl/core/mips_subset_execute_unit.sv
bench/tb_top.sv
